// ----- hw/rtl/nhb_pkg.sv -----
// ----------------------------------------------------------------------------
// NACK history buffer package
// Shared opcodes, constants and the command/status bundles between the
// controller and the datapath of the NACK history buffer.
// ----------------------------------------------------------------------------
package nhb_pkg;

  // Default number of ring entries.
  localparam int DEPTH_DEF = 64;

  // Operation codes carried on in_opcode.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Serial-number half range (0xFFFF / 2) and the span of the lost mask.
  localparam logic [15:0] HALF_RANGE = 16'd32767;
  localparam logic [15:0] MASK_SPAN  = 16'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;      // append an entry from the input beat
    logic clear;     // empty the ring
    logic nop;       // unused opcode, report the count only
    logic q_start;   // latch the sequence number, open the search window
    logic q_read;    // register the probe offset, issue the ring read
    logic q_cmp;     // compare the probed entry, narrow the window
    logic q_fin;     // drop the found entries, publish the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no entries stored
    logic more;      // search window still open after this compare
  } sts_t;

  // True if id lies at or behind seq in serial-number order.
  function automatic logic at_or_behind(input logic [15:0] id, input logic [15:0] seq);
    logic [15:0] fwd;
    logic [15:0] back;
    fwd  = seq - id;
    back = id - seq;
    if (id <= seq) begin
      return fwd < HALF_RANGE;
    end
    return !(back < HALF_RANGE);
  endfunction

endpackage

// ----- hw/rtl/rtp_nack_history_buffer_top.sv -----
// ----------------------------------------------------------------------------
// RTP NACK history buffer
// Ring of generic NACK entries (packet ID plus lost mask) with push,
// dequeue query by sequence number and clear.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken when start is high and busy is low. The
// opcode selects push (packet ID and lost mask are appended, the oldest
// entry is overwritten when the ring is full), dequeue query (the newest
// entry at or behind in_seq_number is found, it and all older entries are
// dropped, and out_was_nacked tells whether it covers the number) or clear.
// Every command yields exactly one result beat: out_valid is high for one
// cycle with out_was_nacked and the entry count after the command.
// Push, clear and the unused opcode return their result on the cycle
// after the command and busy stays low, so such commands may follow
// every cycle. A query runs a binary search over the stored entries
// through the single read port of the ring RAM; each probe issues the
// read address, then compares the registered read data, and a query
// on an empty ring skips the search and goes straight to its result.
// Busy is high for the whole search. The result port cannot stall.
// Reset (synchronous, active low) empties the ring; RAM contents are not
// cleared because only counted entries are ever read.
// ----------------------------------------------------------------------------
module rtp_nack_history_buffer_top #(
  parameter int DEPTH = nhb_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_opcode,
  input  logic [15:0]      in_packet_id,
  input  logic [15:0]      in_lost_mask,
  input  logic [15:0]      in_seq_number,
  output logic             out_valid,
  output logic             out_was_nacked,
  output logic [CNT_W-1:0] out_entry_count
);

  // Command and status bundles between the sequencer and the datapath.
  nhb_pkg::cmd_t cmd;
  nhb_pkg::sts_t sts;

  nhb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath owns the ring RAM, the pointers and the result register.
  nhb_datapath #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_packet_id    (in_packet_id),
    .in_lost_mask    (in_lost_mask),
    .in_seq_number   (in_seq_number),
    .out_valid       (out_valid),
    .out_was_nacked  (out_was_nacked),
    .out_entry_count (out_entry_count)
  );

endmodule

// ----- hw/rtl/nhb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/nhb_ctrl.sv -----
// ----------------------------------------------------------------------------
// NACK history buffer controller
// Sequences push, clear and the binary search of a dequeue query.
// ----------------------------------------------------------------------------
module nhb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_opcode,
  input  nhb_pkg::sts_t sts,
  output nhb_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            nhb_pkg::OP_PUSH:  cmd.push  = 1'b1;
            nhb_pkg::OP_CLEAR: cmd.clear = 1'b1;
            nhb_pkg::OP_QUERY: begin
              cmd.q_start = 1'b1;
              state_nxt   = sts.empty ? S_FIN : S_READ;
            end
            default:           cmd.nop   = 1'b1;
          endcase
        end
      end
      S_READ: begin
        cmd.q_read = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = sts.more ? S_READ : S_FIN;
      end
      S_FIN: begin
        cmd.q_fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ----- hw/rtl/nhb_datapath.sv -----
// ----------------------------------------------------------------------------
// NACK history buffer datapath
// Ring pointers, entry count, search window and the result register.
// ----------------------------------------------------------------------------
module nhb_datapath #(
  parameter int DEPTH = nhb_pkg::DEPTH_DEF,
  parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nhb_pkg::cmd_t    cmd,
  output nhb_pkg::sts_t    sts,
  input  logic [15:0]      in_packet_id,
  input  logic [15:0]      in_lost_mask,
  input  logic [15:0]      in_seq_number,
  output logic             out_valid,
  output logic             out_was_nacked,
  output logic [CNT_W-1:0] out_entry_count
);

  localparam int SUM_W = CNT_W + 1;

  // Control state.
  logic [PTR_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             have_r, have_nxt;

  // Search and result payload.
  logic [15:0]      seq_r, seq_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic [15:0]      fid_r, fid_nxt;
  logic [15:0]      fmask_r, fmask_nxt;
  logic             nacked_r, nacked_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // Ring memory interface.
  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  logic [CNT_W-1:0] mid_c;
  logic [SUM_W-1:0] slot_sum;
  logic [SUM_W-1:0] drop_sum;
  logic [PTR_W-1:0] drop_pos;
  logic [15:0]      gap;
  logic [15:0]      gap_m1;
  logic             hit_c;
  logic             behind_c;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Probe offset and its ring slot: rd_pos + mid stays below twice the depth.
  assign mid_c     = lo_r + ((hi_r - lo_r - 1'b1) >> 1);
  assign slot_sum  = SUM_W'(rd_pos_r) + SUM_W'(mid_c);
  assign ram_raddr = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(slot_sum);

  assign drop_sum  = SUM_W'(rd_pos_r) + SUM_W'(found_r) + 1'b1;
  assign drop_pos  = (drop_sum >= SUM_W'(DEPTH)) ? PTR_W'(drop_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(drop_sum);

  assign behind_c  = nhb_pkg::at_or_behind(ram_rdata[15:0], seq_r);

  assign gap       = seq_r - fid_r;
  assign gap_m1    = gap - 16'd1;
  assign hit_c     = (fid_r == seq_r) ||
                     ((gap >= 16'd1) && (gap <= nhb_pkg::MASK_SPAN) && fmask_r[gap_m1[3:0]]);

  assign ram_we    = cmd.push;

  always_comb begin
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    cnt_nxt       = cnt_r;
    have_nxt      = have_r;
    seq_nxt       = seq_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    fid_nxt       = fid_r;
    fmask_nxt     = fmask_r;
    nacked_nxt    = 1'b0;
    out_valid_nxt = 1'b0;

    if (cmd.push) begin
      if (cnt_r == CNT_W'(DEPTH)) begin
        rd_pos_nxt = ptr_inc(rd_pos_r);
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
      wr_pos_nxt    = ptr_inc(wr_pos_r);
      out_valid_nxt = 1'b1;
    end
    if (cmd.clear) begin
      cnt_nxt       = '0;
      wr_pos_nxt    = '0;
      rd_pos_nxt    = '0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.nop) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.q_start) begin
      seq_nxt   = in_seq_number;
      lo_nxt    = '0;
      hi_nxt    = cnt_r;
      have_nxt  = 1'b0;
      found_nxt = '0;
    end
    if (cmd.q_read) begin
      mid_nxt = mid_c;
    end
    if (cmd.q_cmp) begin
      if (behind_c) begin
        found_nxt = mid_r;
        have_nxt  = 1'b1;
        fid_nxt   = ram_rdata[15:0];
        fmask_nxt = ram_rdata[31:16];
        lo_nxt    = mid_r + 1'b1;
      end else begin
        hi_nxt = mid_r;
      end
    end
    if (cmd.q_fin) begin
      if (have_r) begin
        rd_pos_nxt = drop_pos;
        cnt_nxt    = cnt_r - found_r - 1'b1;
        nacked_nxt = hit_c;
      end
      out_valid_nxt = 1'b1;
    end
    out_cnt_nxt = cnt_nxt;
  end

  assign sts.empty = (cnt_r == '0);
  assign sts.more  = (lo_nxt < hi_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      cnt_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      cnt_r       <= cnt_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r     <= seq_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    found_r   <= found_nxt;
    fid_r     <= fid_nxt;
    fmask_r   <= fmask_nxt;
    if (out_valid_nxt) begin
      nacked_r  <= nacked_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  nhb_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata ({in_lost_mask, in_packet_id}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_was_nacked  = nacked_r;
  assign out_entry_count = out_cnt_r;

endmodule

// ----- hw/rtl/nhb_checker.sv -----
// ----------------------------------------------------------------------------
// NACK history buffer checker
// Port-level assertions on command and result beats.
// ----------------------------------------------------------------------------
module nhb_checker #(
  parameter int DEPTH = nhb_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_opcode,
  input logic             out_valid,
  input logic             out_was_nacked,
  input logic [CNT_W-1:0] out_entry_count
);

  logic accept;
  assign accept = start && !busy;

  // A push, clear or unused-opcode command returns its result on the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode != nhb_pkg::OP_QUERY) |=> out_valid)
    else $error("push/clear result missing");

  // A clear leaves an empty ring and never reports a hit.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == nhb_pkg::OP_CLEAR) |=> (out_entry_count == '0) && !out_was_nacked)
    else $error("clear did not empty the ring");

  // A query holds off further commands while it searches.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == nhb_pkg::OP_QUERY) |=> busy && !out_valid)
    else $error("query did not raise busy");

  // A push never reports a hit and never exceeds the ring depth.
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == nhb_pkg::OP_PUSH) |=>
      !out_was_nacked && (out_entry_count != '0) && (out_entry_count <= CNT_W'(DEPTH)))
    else $error("bad push result");

endmodule

bind rtp_nack_history_buffer_top nhb_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_nhb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_was_nacked  (out_was_nacked),
  .out_entry_count (out_entry_count)
);
